@@ hw/rtl/assert_macros.svh @@
// Assertion helpers included by the query unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

@@ hw/rtl/bbq_pkg.sv @@
// ----------------------------------------------------------------------------
// bbq_pkg
// Shared constants and types of the bounding box city query unit.
// ----------------------------------------------------------------------------
package bbq_pkg;

   localparam int CAPACITY = 4096;
   localparam int MAX_HITS = 64;

   localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int HAW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int HCW = $clog2(MAX_HITS + 1);

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_HIT   = 3'd1;
   localparam logic [2:0] ST_NOHIT = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_ORDER = 3'd4;

   typedef struct packed {
      logic signed [24:0] lat;
      logic signed [25:0] lng;
      logic [31:0]        pop;
   } place_type;

   typedef struct packed {
      logic [IW-1:0] idx;
      logic [31:0]   pop;
   } hit_type;

endpackage

@@ hw/rtl/bbq_ram.sv @@
// ----------------------------------------------------------------------------
// bbq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bounding_box_city_query_unit.sv @@
// ----------------------------------------------------------------------------
// bounding_box_city_query_unit
// Latitude-sorted place table with bounding-box query, hits by population.
//
//   channel | ports                   | direction
//   req     | req_valid/req_stall     | in, one command per transaction
//   rsp     | rsp_valid/rsp_stall     | out, one or more results
//
// Load and clear: result registered at acceptance.
// Query: accept, then two binary searches (a table read and a compare per
// probe, then a close step each), then a scan of the band entries; an entry
// in the box is placed in the hit list by insertion sort, shifting lower
// hits down; hits then go out via hit RAM, table RAM and output, else no-hit.
// Reset clears counts and control; table contents are not cleared.
// A stalled result holds the sequencer; no new command is taken until done.
// ----------------------------------------------------------------------------
module bounding_box_city_query_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [24:0] req_latitude,
   input  logic signed [25:0] req_longitude,
   input  logic [31:0]        req_population,
   input  logic signed [24:0] req_min_lat,
   input  logic signed [24:0] req_max_lat,
   input  logic signed [25:0] req_min_lng,
   input  logic signed [25:0] req_max_lng,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [11:0]        rsp_place_index,
   output logic signed [24:0] rsp_hit_latitude,
   output logic signed [25:0] rsp_hit_longitude,
   output logic [31:0]        rsp_hit_population,
   output logic               rsp_last,
   output logic               rsp_truncated
);
   import bbq_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_SRCH     = 11'b00000000010,
      S_SRCH_CHK = 11'b00000000100,
      S_SCAN     = 11'b00000001000,
      S_SCAN_CHK = 11'b00000010000,
      S_INS      = 11'b00000100000,
      S_INS_CHK  = 11'b00001000000,
      S_EMIT_RD  = 11'b00010000000,
      S_EMIT_TBL = 11'b00100000000,
      S_EMIT_OUT = 11'b01000000000,
      S_NOHIT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic signed [24:0] last_lat_ff, last_lat_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic phase_ff, phase_in;
   logic [CW-1:0] band_lo_ff, band_lo_in, band_hi_ff, band_hi_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] total_ff, total_in;
   logic [HCW-1:0] pos_ff, pos_in, hcnt_ff, hcnt_in, k_ff, k_in;
   logic [31:0] cur_pop_ff, cur_pop_in;
   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic signed [24:0] min_lat_ff, min_lat_in, max_lat_ff, max_lat_in;
   logic signed [25:0] min_lng_ff, min_lng_in, max_lng_ff, max_lng_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_idx_ff, rsp_idx_in;
   logic signed [24:0] rsp_lat_ff, rsp_lat_in;
   logic signed [25:0] rsp_lng_ff, rsp_lng_in;
   logic [31:0] rsp_pop_ff, rsp_pop_in;
   logic rsp_last_ff, rsp_last_in, rsp_trunc_ff, rsp_trunc_in;

   logic t_wr_en, t_rd_en;
   logic [IW-1:0] t_wr_addr, t_rd_addr;
   place_type t_wr_data, t_rd_data;
   logic h_wr_en, h_rd_en;
   logic [HAW-1:0] h_wr_addr, h_rd_addr;
   hit_type h_wr_data, h_rd_data;

   logic [CW:0] mid_sum;
   logic [CW-1:0] mid;
   logic rsp_free, accept, go_right;
   logic [HCW-1:0] pos_m1;

   bbq_ram #(.WIDTH($bits(place_type)), .DEPTH(CAPACITY)) u_table (
      .clock(clock), .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(t_wr_data),
      .rd_en(t_rd_en), .rd_addr(t_rd_addr), .rd_data(t_rd_data)
   );

   bbq_ram #(.WIDTH($bits(hit_type)), .DEPTH(MAX_HITS)) u_hits (
      .clock(clock), .wr_en(h_wr_en), .wr_addr(h_wr_addr), .wr_data(h_wr_data),
      .rd_en(h_rd_en), .rd_addr(h_rd_addr), .rd_data(h_rd_data)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign pos_m1    = pos_ff - HCW'(1);
   assign go_right  = (t_rd_data.lat < (phase_ff ? max_lat_ff : min_lat_ff)) ||
                      (phase_ff && (t_rd_data.lat == max_lat_ff));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      last_lat_in = last_lat_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      phase_in = phase_ff;
      band_lo_in = band_lo_ff;
      band_hi_in = band_hi_ff;
      scan_in = scan_ff;
      total_in = total_ff;
      pos_in = pos_ff;
      hcnt_in = hcnt_ff;
      k_in = k_ff;
      cur_pop_in = cur_pop_ff;
      cur_idx_in = cur_idx_ff;
      min_lat_in = min_lat_ff;
      max_lat_in = max_lat_ff;
      min_lng_in = min_lng_ff;
      max_lng_in = max_lng_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_lat_in = rsp_lat_ff;
      rsp_lng_in = rsp_lng_ff;
      rsp_pop_in = rsp_pop_ff;
      rsp_last_in = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      t_wr_en = 1'b0;
      t_wr_addr = count_ff[IW-1:0];
      t_wr_data = '{lat: req_latitude, lng: req_longitude, pop: req_population};
      t_rd_en = 1'b0;
      t_rd_addr = mid[IW-1:0];
      h_wr_en = 1'b0;
      h_wr_addr = pos_ff[HAW-1:0];
      h_wr_data = '{idx: cur_idx_ff, pop: cur_pop_ff};
      h_rd_en = 1'b0;
      h_rd_addr = pos_m1[HAW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = ST_DONE;
               rsp_idx_in = '0;
               rsp_lat_in = '0;
               rsp_lng_in = '0;
               rsp_pop_in = '0;
               rsp_last_in = 1'b1;
               rsp_trunc_in = 1'b0;
               case (req_cmd)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CW'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else if ((count_ff != '0) && (req_latitude < last_lat_ff)) begin
                        rsp_status_in = ST_ORDER;
                     end else begin
                        t_wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        last_lat_in = req_latitude;
                        rsp_idx_in = 12'(count_ff);
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in = '0;
                  end
                  CMD_QUERY: begin
                     min_lat_in = req_min_lat;
                     max_lat_in = req_max_lat;
                     min_lng_in = req_min_lng;
                     max_lng_in = req_max_lng;
                     lo_in = '0;
                     hi_in = count_ff;
                     phase_in = 1'b0;
                     state_in = S_SRCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               t_rd_en = 1'b1;
               state_in = S_SRCH_CHK;
            end else if (!phase_ff) begin
               band_lo_in = lo_ff;
               lo_in = '0;
               hi_in = count_ff;
               phase_in = 1'b1;
            end else begin
               band_hi_in = lo_ff;
               scan_in = band_lo_ff;
               hcnt_in = '0;
               total_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SRCH_CHK: begin
            if (go_right) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH;
         end
         S_SCAN: begin
            t_rd_addr = scan_ff[IW-1:0];
            if (scan_ff < band_hi_ff) begin
               t_rd_en = 1'b1;
               state_in = S_SCAN_CHK;
            end else if (hcnt_ff == '0) begin
               state_in = S_NOHIT;
            end else begin
               k_in = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_SCAN_CHK: begin
            if ((t_rd_data.lng >= min_lng_ff) && (t_rd_data.lng <= max_lng_ff)) begin
               total_in = total_ff + CW'(1);
               cur_pop_in = t_rd_data.pop;
               cur_idx_in = scan_ff[IW-1:0];
               pos_in = hcnt_ff;
               state_in = S_INS;
            end else begin
               scan_in = scan_ff + CW'(1);
               state_in = S_SCAN;
            end
         end
         S_INS, S_INS_CHK: begin
            if ((state_ff == S_INS) && (pos_ff != '0)) begin
               h_rd_en = 1'b1;
               state_in = S_INS_CHK;
            end else if ((state_ff == S_INS_CHK) && (h_rd_data.pop < cur_pop_ff)) begin
               h_wr_en = (pos_ff < HCW'(MAX_HITS));
               h_wr_data = h_rd_data;
               pos_in = pos_m1;
               state_in = S_INS;
            end else begin
               if (pos_ff < HCW'(MAX_HITS)) begin
                  h_wr_en = 1'b1;
                  if (hcnt_ff < HCW'(MAX_HITS)) begin
                     hcnt_in = hcnt_ff + HCW'(1);
                  end
               end
               scan_in = scan_ff + CW'(1);
               state_in = S_SCAN;
            end
         end
         S_EMIT_RD: begin
            h_rd_en = 1'b1;
            h_rd_addr = k_ff[HAW-1:0];
            state_in = S_EMIT_TBL;
         end
         S_EMIT_TBL: begin
            t_rd_en = 1'b1;
            t_rd_addr = h_rd_data.idx;
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_HIT;
               rsp_idx_in = 12'(h_rd_data.idx);
               rsp_lat_in = t_rd_data.lat;
               rsp_lng_in = t_rd_data.lng;
               rsp_pop_in = t_rd_data.pop;
               rsp_last_in = ((k_ff + HCW'(1)) == hcnt_ff);
               rsp_trunc_in = (total_ff > CW'(MAX_HITS));
               k_in = k_ff + HCW'(1);
               state_in = ((k_ff + HCW'(1)) == hcnt_ff) ? S_IDLE : S_EMIT_RD;
            end
         end
         S_NOHIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_NOHIT;
               rsp_idx_in = '0;
               rsp_lat_in = '0;
               rsp_lng_in = '0;
               rsp_pop_in = '0;
               rsp_last_in = 1'b1;
               rsp_trunc_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         hcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hcnt_ff <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_lat_ff <= last_lat_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      phase_ff <= phase_in;
      band_lo_ff <= band_lo_in;
      band_hi_ff <= band_hi_in;
      scan_ff <= scan_in;
      total_ff <= total_in;
      pos_ff <= pos_in;
      k_ff <= k_in;
      cur_pop_ff <= cur_pop_in;
      cur_idx_ff <= cur_idx_in;
      min_lat_ff <= min_lat_in;
      max_lat_ff <= max_lat_in;
      min_lng_ff <= min_lng_in;
      max_lng_ff <= max_lng_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_lat_ff <= rsp_lat_in;
      rsp_lng_ff <= rsp_lng_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_last_ff <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_place_index = rsp_idx_ff;
   assign rsp_hit_latitude = rsp_lat_ff;
   assign rsp_hit_longitude = rsp_lng_ff;
   assign rsp_hit_population = rsp_pop_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

   `ASSERT_CLK(a_hcnt_bound, clock, reset, hcnt_ff <= HCW'(MAX_HITS))
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   `ASSERT_CLK(a_scan_in_band, clock, reset, (state_ff == S_SCAN_CHK) |-> (scan_ff < band_hi_ff))
   `ASSERT_CLK(a_emit_needs_hits, clock, reset, (state_ff == S_EMIT_OUT) |-> (k_ff < hcnt_ff))

endmodule
